// ===== design/per_peer_message_reassembler_macros.svh =====
// Assertion macros shared by the reassembler checker.
`ifndef PER_PEER_MESSAGE_REASSEMBLER_MACROS_SVH
`define PER_PEER_MESSAGE_REASSEMBLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPMR_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ppmr: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define PPMR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ppmr: next-cycle property failed");

`endif

// ===== design/ppmr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmr_pkg
// Types and constants shared by the per-peer message reassembler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppmr_pkg;

  localparam int unsigned MSG_LEN_W   = 11;
  localparam int unsigned PEER_SLOT_W = 2;
  localparam int unsigned HDR_LEN     = 8;
  localparam logic [7:0]  HDR_BYTE0   = 8'h01;
  localparam logic [7:0]  HDR_BYTE1   = 8'hFE;

  typedef enum logic [1:0] {
    STAT_NONE     = 2'd0,
    STAT_COMPLETE = 2'd1,
    STAT_IGNORED  = 2'd2,
    STAT_READ     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SCAN_OVERRUN = 2'd0,
    SCAN_BAD_HDR = 2'd1,
    SCAN_OVERSIZE = 2'd2
  } scan_ctx_e;

  typedef struct packed {
    logic go;
    logic skip_first;
  } scan_cmd_t;

  typedef struct packed {
    status_e                status;
    logic [PEER_SLOT_W-1:0] peer_slot;
    logic [MSG_LEN_W-1:0]   message_length;
    logic [7:0]             read_data;
    logic [31:0]            gap_count;
    logic [31:0]            resync_count;
  } result_t;

endpackage

`default_nettype wire

// ===== design/ppmr_store.sv =====
// ----------------------------------------------------------------------------
// ppmr_store
// Byte store for all peer buffers: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppmr_store #(
  parameter int DEPTH = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/ppmr_scan.sv =====
// ----------------------------------------------------------------------------
// ppmr_scan
// Resync engine: searches a peer buffer for a header start and moves the
// bytes from there to the front, one byte at a time, each read then written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppmr_scan #(
  parameter int BUFFER_BYTES = 1024,
  localparam int FILL_W = $clog2(BUFFER_BYTES + 1),
  localparam int IDX_W  = $clog2(BUFFER_BYTES)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ppmr_pkg::scan_cmd_t cmd_i,
  input  wire logic [FILL_W-1:0]   fill_i,
  output      logic                done_o,
  output      logic [FILL_W-1:0]   new_fill_o,
  output      logic                rd_en_o,
  output      logic [IDX_W-1:0]    rd_idx_o,
  input  wire logic [7:0]          rd_data_i,
  output      logic                wr_en_o,
  output      logic [IDX_W-1:0]    wr_idx_o,
  output      logic [7:0]          wr_data_o
);

  typedef enum logic [4:0] {
    SC_IDLE = 5'b00001,
    SC_SRD  = 5'b00010,
    SC_SCHK = 5'b00100,
    SC_CRD  = 5'b01000,
    SC_CWR  = 5'b10000
  } scan_state_e;

  scan_state_e       state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              skip_q, skip_d;
  logic [FILL_W-1:0] j_q, j_d;
  logic              prev01_q, prev01_d;
  logic [FILL_W-1:0] src_q, src_d;
  logic [FILL_W-1:0] k_q, k_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  logic              done_q, done_d;
  logic [FILL_W-1:0] nf_q, nf_d;
  logic [FILL_W-1:0] start_v;
  logic [FILL_W-1:0] match_i;
  logic [FILL_W-1:0] src_idx;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    skip_d    = skip_q;
    j_d       = j_q;
    prev01_d  = prev01_q;
    src_d     = src_q;
    k_d       = k_q;
    rem_d     = rem_q;
    done_d    = 1'b0;
    nf_d      = nf_q;
    rd_en_o   = 1'b0;
    rd_idx_o  = '0;
    wr_en_o   = 1'b0;
    wr_idx_o  = '0;
    wr_data_o = '0;
    start_v   = FILL_W'(cmd_i.skip_first);
    match_i   = j_q - FILL_W'(1);
    src_idx   = src_q + k_q;
    case (state_q)
      SC_IDLE: begin
        if (cmd_i.go) begin
          fill_d   = fill_i;
          skip_d   = cmd_i.skip_first;
          j_d      = start_v;
          prev01_d = 1'b0;
          if (start_v >= fill_i) begin
            done_d = 1'b1;
            nf_d   = '0;
          end else begin
            state_d = SC_SRD;
          end
        end
      end
      SC_SRD: begin
        rd_en_o  = 1'b1;
        rd_idx_o = j_q[IDX_W-1:0];
        state_d  = SC_SCHK;
      end
      SC_SCHK: begin
        if (j_q > FILL_W'(skip_q) && prev01_q && rd_data_i == ppmr_pkg::HDR_BYTE1) begin
          if (match_i == '0) begin
            done_d  = 1'b1;
            nf_d    = fill_q;
            state_d = SC_IDLE;
          end else begin
            src_d   = match_i;
            k_d     = '0;
            rem_d   = fill_q - match_i;
            state_d = SC_CRD;
          end
        end else if ((j_q + FILL_W'(1)) < fill_q) begin
          prev01_d = (rd_data_i == ppmr_pkg::HDR_BYTE0);
          j_d      = j_q + FILL_W'(1);
          state_d  = SC_SRD;
        end else begin
          // keep a trailing lone header start byte
          if (rd_data_i == ppmr_pkg::HDR_BYTE0) begin
            wr_en_o   = 1'b1;
            wr_data_o = ppmr_pkg::HDR_BYTE0;
            nf_d      = FILL_W'(1);
          end else begin
            nf_d = '0;
          end
          done_d  = 1'b1;
          state_d = SC_IDLE;
        end
      end
      SC_CRD: begin
        rd_en_o  = 1'b1;
        rd_idx_o = src_idx[IDX_W-1:0];
        state_d  = SC_CWR;
      end
      SC_CWR: begin
        wr_en_o   = 1'b1;
        wr_idx_o  = k_q[IDX_W-1:0];
        wr_data_o = rd_data_i;
        k_d       = k_q + FILL_W'(1);
        if ((k_q + FILL_W'(1)) == rem_q) begin
          done_d  = 1'b1;
          nf_d    = rem_q;
          state_d = SC_IDLE;
        end else begin
          state_d = SC_CRD;
        end
      end
      default: state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q   <= fill_d;
    skip_q   <= skip_d;
    j_q      <= j_d;
    prev01_q <= prev01_d;
    src_q    <= src_d;
    k_q      <= k_d;
    rem_q    <= rem_d;
    nf_q     <= nf_d;
  end

  assign done_o     = done_q;
  assign new_fill_o = nf_q;

endmodule

`default_nettype wire

// ===== design/per_peer_message_reassembler.sv =====
// ----------------------------------------------------------------------------
// per_peer_message_reassembler
// Reassembles framed messages from per-peer segment byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one request per byte: tuser[0] selects payload
//   (0) or buffer read (1), tuser[1] marks the first byte of a segment and
//   tlast its last byte. Master channel returns exactly one result per
//   request, status in tuser.
//   A plain payload byte is written in the processing state, a read passes
//   through a read state for the registered store data, and a last byte
//   adds a header check state. A resync pass reads the buffer up to a header
//   start and reads then writes each moved byte; the resync engine waits out every store read.
//   One request is worked on at a time; the next is taken as soon as the
//   result sits in the output register, even if the receiver stalls.
//   Reset empties the peer table and clears the counters; buffer bytes are
//   undefined until written and need no clearing pass.
//   A stalled receiver holds the result; the block then finishes the
//   following request and waits with it until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_peer_message_reassembler #(
  parameter int PEER_SLOTS   = 4,
  parameter int BUFFER_BYTES = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // src_mac[47:0], seq[79:48], data_byte[87:80], read_slot[89:88],
  // read_index[99:90], zero pad[103:100]
  input  wire logic [103:0] s_axis_tdata,
  // mode[0], first_of_segment[1]
  input  wire logic [1:0]   s_axis_tuser,
  input  wire logic         s_axis_tlast,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // peer_slot[1:0], message_length[12:2], read_data[20:13],
  // gap_count[52:21], resync_count[84:53], zero pad[87:85]
  output      logic [87:0]  m_axis_tdata,
  // status[1:0]
  output      logic [1:0]   m_axis_tuser
);

  localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
  localparam int IDX_W  = $clog2(BUFFER_BYTES);
  localparam int DEPTH  = PEER_SLOTS * BUFFER_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LenW   = ppmr_pkg::MSG_LEN_W;
  localparam int PsW    = ppmr_pkg::PEER_SLOT_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PROC  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [IDX_W-1:0] idx);
    store_addr = ADDR_W'(slot * BUFFER_BYTES + idx);
  endfunction

  state_e state_q, state_d;

  // request fields
  logic        mode_q, first_q, last_q;
  logic [47:0] mac_q;
  logic [31:0] seq_q;
  logic [7:0]  byte_q;
  logic [1:0]  rslot_q;
  logic [9:0]  ridx_q;

  // peer table
  logic [PEER_SLOTS-1:0] used_q, used_d;
  logic [PEER_SLOTS-1:0] hasseq_q, hasseq_d;
  logic [47:0]           addr_q [PEER_SLOTS];
  logic [47:0]           addr_d [PEER_SLOTS];
  logic [31:0]           expseq_q [PEER_SLOTS];
  logic [31:0]           expseq_d [PEER_SLOTS];
  logic [FILL_W-1:0]     fill_q [PEER_SLOTS];
  logic [FILL_W-1:0]     fill_d [PEER_SLOTS];
  logic [FILL_W-1:0]     want_q [PEER_SLOTS];
  logic [FILL_W-1:0]     want_d [PEER_SLOTS];
  logic [7:0]            hdr_q [PEER_SLOTS][ppmr_pkg::HDR_LEN];
  logic [7:0]            hdr_d [PEER_SLOTS][ppmr_pkg::HDR_LEN];

  logic [SLOT_W-1:0]   cur_q, cur_d;
  logic                ignored_q, ignored_d;
  logic                overran_q, overran_d;
  logic [31:0]         gap_q, gap_d;
  logic [31:0]         resync_q, resync_d;
  ppmr_pkg::scan_ctx_e ctx_q, ctx_d;

  ppmr_pkg::result_t out_q, out_d, hold_q, hold_d, res;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              fin;

  // store ports
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  // resync engine
  ppmr_pkg::scan_cmd_t scan_cmd;
  logic [FILL_W-1:0]   scan_fill, scan_nf;
  logic                scan_done, scan_rd_en, scan_wr_en;
  logic [IDX_W-1:0]    scan_rd_idx, scan_wr_idx;
  logic [7:0]          scan_wr_data;

  // request decode
  logic              hit, free_ok, gap_hit, hs;
  logic [SLOT_W-1:0] hit_idx, free_idx, sl;
  logic [FILL_W-1:0] fill_cur, f, w;
  logic              go_on;
  logic [32:0]       want_ext;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    hasseq_d    = hasseq_q;
    addr_d      = addr_q;
    expseq_d    = expseq_q;
    fill_d      = fill_q;
    want_d      = want_q;
    hdr_d       = hdr_q;
    cur_d       = cur_q;
    ignored_d   = ignored_q;
    overran_d   = overran_q;
    gap_d       = gap_q;
    resync_d    = resync_q;
    ctx_d       = ctx_q;
    out_d       = out_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    scan_cmd    = '0;
    scan_fill   = '0;
    fin         = 1'b0;
    res         = '0;
    hit         = 1'b0;
    hit_idx     = '0;
    free_ok     = 1'b0;
    free_idx    = '0;
    gap_hit     = 1'b0;
    hs          = 1'b0;
    sl          = cur_q;
    fill_cur    = '0;
    go_on       = 1'b0;
    f           = fill_q[cur_q];
    w           = want_q[cur_q];
    want_ext    = 33'(ppmr_pkg::HDR_LEN) + 33'({hdr_q[cur_q][4], hdr_q[cur_q][5],
                                                hdr_q[cur_q][6], hdr_q[cur_q][7]});

    for (int i = 0; i < PEER_SLOTS; i++) begin
      if (used_q[i] && addr_q[i] == mac_q && !hit) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!used_q[i] && !free_ok) begin
        free_ok  = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_PROC;
        end
      end
      ST_PROC: begin
        if (mode_q) begin
          if (32'(rslot_q) < 32'(PEER_SLOTS) && 32'(ridx_q) < 32'(BUFFER_BYTES)) begin
            mem_re    = 1'b1;
            mem_raddr = store_addr(SLOT_W'(rslot_q), IDX_W'(ridx_q));
            state_d   = ST_READ;
          end else begin
            fin        = 1'b1;
            res.status = ppmr_pkg::STAT_READ;
          end
        end else if (first_q) begin
          overran_d = 1'b0;
          if (!hit && !free_ok) begin
            ignored_d  = 1'b1;
            fin        = 1'b1;
            res.status = ppmr_pkg::STAT_IGNORED;
          end else begin
            ignored_d = 1'b0;
            sl        = hit ? hit_idx : free_idx;
            cur_d     = sl;
            hs        = hit && hasseq_q[sl];
            gap_hit   = hs && (seq_q != expseq_q[sl]);
            if (!hit) begin
              used_d[sl] = 1'b1;
              addr_d[sl] = mac_q;
            end
            if (!hit || gap_hit) begin
              want_d[sl] = '0;
            end
            if (gap_hit) begin
              gap_d = gap_q + 32'd1;
            end
            hasseq_d[sl] = 1'b1;
            expseq_d[sl] = seq_q + 32'd1;
            fill_cur     = (!hit || gap_hit) ? '0 : fill_q[sl];
            fill_d[sl]   = fill_cur;
            go_on        = 1'b1;
          end
        end else if (ignored_q) begin
          fin        = 1'b1;
          res.status = ppmr_pkg::STAT_IGNORED;
        end else if (!used_q[cur_q]) begin
          fin = 1'b1;
        end else begin
          expseq_d[cur_q] = expseq_q[cur_q] + 32'd1;
          fill_cur        = fill_q[cur_q];
          go_on           = !overran_q;
          fin             = overran_q;
        end

        if (go_on) begin
          if (fill_cur < FILL_W'(BUFFER_BYTES)) begin
            mem_we     = 1'b1;
            mem_waddr  = store_addr(sl, fill_cur[IDX_W-1:0]);
            mem_wdata  = byte_q;
            fill_d[sl] = fill_cur + FILL_W'(1);
            if (fill_cur < FILL_W'(ppmr_pkg::HDR_LEN)) begin
              hdr_d[sl][fill_cur[2:0]] = byte_q;
            end
            if (last_q) begin
              state_d = ST_CHECK;
            end else begin
              fin = 1'b1;
            end
          end else begin
            // buffer full: resync and drop the rest of the segment
            overran_d    = 1'b1;
            scan_cmd.go  = 1'b1;
            scan_fill    = fill_cur;
            ctx_d        = ppmr_pkg::SCAN_OVERRUN;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_READ: begin
        fin           = 1'b1;
        res.status    = ppmr_pkg::STAT_READ;
        res.read_data = mem_rdata;
      end
      ST_CHECK: begin
        if (w == '0) begin
          if (f < FILL_W'(ppmr_pkg::HDR_LEN) || hdr_q[cur_q][0] != ppmr_pkg::HDR_BYTE0 ||
              hdr_q[cur_q][1] != ppmr_pkg::HDR_BYTE1) begin
            if (f >= FILL_W'(2)) begin
              scan_cmd.go = 1'b1;
              scan_fill   = f;
              ctx_d       = ppmr_pkg::SCAN_BAD_HDR;
              state_d     = ST_SCAN;
            end else begin
              fin = 1'b1;
            end
          end else if (want_ext > 33'(BUFFER_BYTES)) begin
            // bogus length: drop the first header byte and resync
            scan_cmd.go         = 1'b1;
            scan_cmd.skip_first = 1'b1;
            scan_fill           = f;
            ctx_d               = ppmr_pkg::SCAN_OVERSIZE;
            state_d             = ST_SCAN;
          end else if (33'(f) >= want_ext) begin
            fill_d[cur_q]      = '0;
            want_d[cur_q]      = '0;
            fin                = 1'b1;
            res.status         = ppmr_pkg::STAT_COMPLETE;
            res.peer_slot      = PsW'(cur_q);
            res.message_length = LenW'(want_ext);
          end else begin
            want_d[cur_q] = want_ext[FILL_W-1:0];
            fin           = 1'b1;
          end
        end else if (f >= w) begin
          fill_d[cur_q]      = '0;
          want_d[cur_q]      = '0;
          fin                = 1'b1;
          res.status         = ppmr_pkg::STAT_COMPLETE;
          res.peer_slot      = PsW'(cur_q);
          res.message_length = LenW'(w);
        end else begin
          fin = 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          fin = 1'b1;
          case (ctx_q)
            ppmr_pkg::SCAN_OVERRUN: begin
              fill_d[cur_q] = scan_nf;
              resync_d      = resync_q + 32'd1;
            end
            ppmr_pkg::SCAN_BAD_HDR: begin
              if (scan_nf != f) begin
                resync_d = resync_q + 32'd1;
              end
              fill_d[cur_q] = (scan_nf > FILL_W'(BUFFER_BYTES - ppmr_pkg::HDR_LEN)) ?
                              '0 : scan_nf;
            end
            ppmr_pkg::SCAN_OVERSIZE: begin
              fill_d[cur_q] = scan_nf;
              want_d[cur_q] = '0;
              resync_d      = resync_q + 32'd1;
            end
            default: fill_d[cur_q] = scan_nf;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // resync engine owns the store while it runs
    if (scan_rd_en) begin
      mem_re    = 1'b1;
      mem_raddr = store_addr(cur_q, scan_rd_idx);
    end
    if (scan_wr_en) begin
      mem_we    = 1'b1;
      mem_waddr = store_addr(cur_q, scan_wr_idx);
      mem_wdata = scan_wr_data;
      if (32'(scan_wr_idx) < 32'(ppmr_pkg::HDR_LEN)) begin
        hdr_d[cur_q][scan_wr_idx[2:0]] = scan_wr_data;
      end
    end

    res.gap_count    = gap_d;
    res.resync_count = resync_d;
    if (fin) begin
      if (out_free) begin
        out_d       = res;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end else begin
        hold_d  = res;
        state_d = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      hasseq_q    <= '0;
      cur_q       <= '0;
      ignored_q   <= 1'b0;
      overran_q   <= 1'b0;
      gap_q       <= '0;
      resync_q    <= '0;
      out_valid_q <= 1'b0;
      ctx_q       <= ppmr_pkg::SCAN_OVERRUN;
      for (int i = 0; i < PEER_SLOTS; i++) begin
        fill_q[i] <= '0;
        want_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      hasseq_q    <= hasseq_d;
      cur_q       <= cur_d;
      ignored_q   <= ignored_d;
      overran_q   <= overran_d;
      gap_q       <= gap_d;
      resync_q    <= resync_d;
      out_valid_q <= out_valid_d;
      ctx_q       <= ctx_d;
      fill_q      <= fill_d;
      want_q      <= want_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    expseq_q <= expseq_d;
    hdr_q    <= hdr_d;
    out_q    <= out_d;
    hold_q   <= hold_d;
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q  <= s_axis_tuser[0];
      first_q <= s_axis_tuser[1];
      last_q  <= s_axis_tlast;
      mac_q   <= s_axis_tdata[47:0];
      seq_q   <= s_axis_tdata[79:48];
      byte_q  <= s_axis_tdata[87:80];
      rslot_q <= s_axis_tdata[89:88];
      ridx_q  <= s_axis_tdata[99:90];
    end
  end

  ppmr_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ppmr_scan #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (scan_cmd),
    .fill_i     (scan_fill),
    .done_o     (scan_done),
    .new_fill_o (scan_nf),
    .rd_en_o    (scan_rd_en),
    .rd_idx_o   (scan_rd_idx),
    .rd_data_i  (mem_rdata),
    .wr_en_o    (scan_wr_en),
    .wr_idx_o   (scan_wr_idx),
    .wr_data_o  (scan_wr_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {3'b000, out_q.resync_count, out_q.gap_count, out_q.read_data,
                          out_q.message_length, out_q.peer_slot};

endmodule

`default_nettype wire

// ===== design/ppmr_checker.sv =====
// ----------------------------------------------------------------------------
// ppmr_checker
// Port-level properties of the per-peer message reassembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "per_peer_message_reassembler_macros.svh"

module ppmr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // stalled result holds
  `PPMR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // one request at a time: busy right after a request is taken
  `PPMR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // slot and length only on a completed message
  `PPMR_ASSERT_SAME(a_len_only_complete, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ppmr_pkg::STAT_COMPLETE), m_axis_tdata[12:0] == 13'd0)

  // read data only in read results
  `PPMR_ASSERT_SAME(a_data_only_read, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ppmr_pkg::STAT_READ), m_axis_tdata[20:13] == 8'd0)

endmodule

bind per_peer_message_reassembler ppmr_checker u_checker (.*);

`default_nettype wire
